### rtl/x86_64_instruction_byte_encoder_defines.svh
// Assertion macros for the x86-64 instruction byte encoder.
// Used by the port checker; depends on nothing else.
`ifndef X86_64_INSTRUCTION_BYTE_ENCODER_DEFINES_SVH
`define X86_64_INSTRUCTION_BYTE_ENCODER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define XIE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define XIE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/xie_pkg.sv
// Shared types and constants for the x86-64 instruction byte encoder.
// No dependencies.
package xie_pkg;
	localparam int MAX_PAD_BYTES = 64;
	localparam int DESC_BYTES = 15;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	// Request kinds.
	localparam logic [4:0] K_MOV_RR = 5'd0;
	localparam logic [4:0] K_MOV_RI = 5'd1;
	localparam logic [4:0] K_MOV_RM = 5'd2;
	localparam logic [4:0] K_MOV_MR = 5'd3;
	localparam logic [4:0] K_ADD_RR = 5'd4;
	localparam logic [4:0] K_ADD_RI = 5'd5;
	localparam logic [4:0] K_SUB_RR = 5'd6;
	localparam logic [4:0] K_IMUL_RR = 5'd7;
	localparam logic [4:0] K_CMP_RR = 5'd8;
	localparam logic [4:0] K_CMP_RI = 5'd9;
	localparam logic [4:0] K_TEST_RR = 5'd10;
	localparam logic [4:0] K_JMP = 5'd11;
	localparam logic [4:0] K_JCC = 5'd12;
	localparam logic [4:0] K_CALL_REL = 5'd13;
	localparam logic [4:0] K_CALL_R = 5'd14;
	localparam logic [4:0] K_RET = 5'd15;
	localparam logic [4:0] K_PUSH = 5'd16;
	localparam logic [4:0] K_POP = 5'd17;
	localparam logic [4:0] K_LEA = 5'd18;
	localparam logic [4:0] K_NOP = 5'd19;
	localparam logic [4:0] K_NOP_N = 5'd20;
	localparam logic [4:0] K_MOVSD = 5'd21;
	localparam logic [4:0] K_ADDSD = 5'd22;
	localparam logic [4:0] K_SUBSD = 5'd23;
	localparam logic [4:0] K_MULSD = 5'd24;

	localparam logic [7:0] B_REX = 8'h40;
	localparam logic [7:0] B_NOP = 8'h90;

	// One classified instruction: a byte list or a padding run.
	typedef struct packed {
		logic [DESC_BYTES-1:0][7:0] bytes;
		logic [3:0] len;
		logic is_pad;
		logic [6:0] pad;
	} desc_t;
endpackage

### rtl/xie_front.sv
// Front end: accepts a request and builds its byte list combinationally.
// Depends on xie_pkg.
module xie_front (
	input logic [4:0] req_type,
	input logic [3:0] first_reg,
	input logic [3:0] second_reg,
	input logic [3:0] cond_code,
	input logic signed [31:0] displacement,
	input logic signed [63:0] immediate,
	input logic [6:0] pad_count,
	output xie_pkg::desc_t desc,
	output logic emits
);
	import xie_pkg::*;

	logic [DESC_BYTES-1:0][7:0] b;
	logic [3:0] n;
	logic [1:0] md;
	logic [3:0] mreg;
	logic [3:0] mbase;
	logic [31:0] d;
	logic [7:0] rex;
	logic [7:0] sop;

	// Append helper state is kept as a running count in n.
	always_comb begin
		b = '0;
		n = '0;
		d = displacement;
		mreg = (req_type == K_MOV_MR) ? second_reg : first_reg;
		mbase = (req_type == K_MOV_MR) ? first_reg : second_reg;
		if (req_type == K_LEA)
			md = 2'd2;
		else if (d == 32'd0 && mbase[2:0] != 3'd5)
			md = 2'd0;
		else if ((d + 32'd128) < 32'd256)
			md = 2'd1;
		else
			md = 2'd2;
		rex = B_REX;
		sop = 8'h10;
		desc.is_pad = 1'b0;
		desc.pad = '0;
		case (req_type)
			K_MOV_RR, K_ADD_RR, K_SUB_RR, K_CMP_RR, K_TEST_RR: begin
				b[0] = B_REX | 8'h08 | {5'd0, second_reg[3], 1'b0, first_reg[3]};
				case (req_type)
					K_MOV_RR: b[1] = 8'h89;
					K_ADD_RR: b[1] = 8'h01;
					K_SUB_RR: b[1] = 8'h29;
					K_CMP_RR: b[1] = 8'h39;
					default: b[1] = 8'h85;
				endcase
				b[2] = {2'b11, second_reg[2:0], first_reg[2:0]};
				n = 4'd3;
			end
			K_MOV_RI: begin
				b[0] = B_REX | 8'h08 | {7'd0, first_reg[3]};
				b[1] = 8'hB8 + {5'd0, first_reg[2:0]};
				for (int i = 0; i < 8; i++)
					b[2+i] = immediate[8*i +: 8];
				n = 4'd10;
			end
			K_MOV_RM, K_MOV_MR, K_LEA: begin
				b[0] = B_REX | 8'h08 | {5'd0, mreg[3], 1'b0, mbase[3]};
				b[1] = (req_type == K_MOV_RM) ? 8'h8B :
					(req_type == K_LEA) ? 8'h8D : 8'h89;
				b[2] = {md, mreg[2:0], mbase[2:0]};
				n = 4'd3;
				if (mbase[2:0] == 3'd4) begin
					b[3] = 8'h24;
					n = 4'd4;
				end
				if (md == 2'd1) begin
					b[n] = d[7:0];
					n = n + 4'd1;
				end else if (md == 2'd2) begin
					for (int i = 0; i < 4; i++)
						b[n + 4'(i)] = d[8*i +: 8];
					n = n + 4'd4;
				end
			end
			K_ADD_RI, K_CMP_RI: begin
				b[0] = B_REX | 8'h08 | {7'd0, first_reg[3]};
				b[1] = 8'h81;
				b[2] = {2'b11, (req_type == K_ADD_RI) ? 3'd0 : 3'd7, first_reg[2:0]};
				for (int i = 0; i < 4; i++)
					b[3+i] = immediate[8*i +: 8];
				n = 4'd7;
			end
			K_IMUL_RR: begin
				b[0] = B_REX | 8'h08 | {5'd0, first_reg[3], 1'b0, second_reg[3]};
				b[1] = 8'h0F;
				b[2] = 8'hAF;
				b[3] = {2'b11, first_reg[2:0], second_reg[2:0]};
				n = 4'd4;
			end
			K_JMP, K_CALL_REL: begin
				b[0] = (req_type == K_JMP) ? 8'hE9 : 8'hE8;
				for (int i = 0; i < 4; i++)
					b[1+i] = d[8*i +: 8];
				n = 4'd5;
			end
			K_JCC: begin
				b[0] = 8'h0F;
				b[1] = 8'h80 + {4'd0, cond_code};
				for (int i = 0; i < 4; i++)
					b[2+i] = d[8*i +: 8];
				n = 4'd6;
			end
			K_CALL_R: begin
				if (first_reg[3]) begin
					b[0] = 8'h41;
					n = 4'd1;
				end
				b[n] = 8'hFF;
				b[n+4'd1] = {2'b11, 3'd2, first_reg[2:0]};
				n = n + 4'd2;
			end
			K_RET: begin
				b[0] = 8'hC3;
				n = 4'd1;
			end
			K_PUSH, K_POP: begin
				if (first_reg[3]) begin
					b[0] = 8'h41;
					n = 4'd1;
				end
				b[n] = ((req_type == K_PUSH) ? 8'h50 : 8'h58) + {5'd0, first_reg[2:0]};
				n = n + 4'd1;
			end
			K_NOP: begin
				b[0] = B_NOP;
				n = 4'd1;
			end
			K_NOP_N: begin
				desc.is_pad = 1'b1;
				desc.pad = (pad_count > 7'(MAX_PAD_BYTES)) ? 7'(MAX_PAD_BYTES) : pad_count;
			end
			K_MOVSD, K_ADDSD, K_SUBSD, K_MULSD: begin
				case (req_type)
					K_MOVSD: sop = 8'h10;
					K_ADDSD: sop = 8'h58;
					K_SUBSD: sop = 8'h5C;
					default: sop = 8'h59;
				endcase
				rex = B_REX | {5'd0, first_reg[3], 1'b0, second_reg[3]};
				b[0] = 8'hF2;
				n = 4'd1;
				if (first_reg[3] || second_reg[3]) begin
					b[1] = rex;
					n = 4'd2;
				end
				b[n] = 8'h0F;
				b[n+4'd1] = sop;
				b[n+4'd2] = {2'b11, first_reg[2:0], second_reg[2:0]};
				n = n + 4'd3;
			end
			default: n = '0;
		endcase
		desc.bytes = b;
		desc.len = n;
		emits = (n != 4'd0) || (desc.is_pad && desc.pad != 7'd0);
	end
endmodule

### rtl/xie_queue.sv
// Short queue of classified instructions between front and back end.
// Depends on xie_pkg.
module xie_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input xie_pkg::desc_t wdata,
	output logic full,
	input logic pop,
	output logic empty,
	output xie_pkg::desc_t rdata
);
	import xie_pkg::*;

	desc_t mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wp_q;
	logic [QUEUE_AW-1:0] rp_q;
	logic [QUEUE_AW:0] cnt_q;

	assign full = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wp_q] <= wdata;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full)
				wp_q <= wp_q + 1'b1;
			if (pop && !empty)
				rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QUEUE_AW+1)'(push && !full) - (QUEUE_AW+1)'(pop && !empty);
		end
	end
endmodule

### rtl/xie_back.sv
// Back end: walks one classified instruction and sends one byte per beat.
// Depends on xie_pkg.
module xie_back (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input xie_pkg::desc_t desc,
	output logic pop,
	output logic out_valid,
	output logic [7:0] out_byte,
	output logic out_last,
	input logic out_stall
);
	import xie_pkg::*;

	logic [3:0] idx_q;
	logic [6:0] left_q;
	logic [3:0] run_q;
	logic started_q;
	logic [6:0] left;
	logic [3:0] run;
	logic fire;
	logic last;

	// Padding: each nine-byte run while nine remain, then single bytes.
	always_comb begin
		left = started_q ? left_q : desc.pad;
		run = started_q ? run_q : 4'd0;
		out_valid = !empty;
		out_byte = desc.bytes[idx_q];
		last = (idx_q + 4'd1 == desc.len);
		if (desc.is_pad) begin
			if (run != 4'd0 || left >= 7'd9) begin
				case (run)
					4'd0: out_byte = 8'h66;
					4'd1: out_byte = 8'h0F;
					4'd2: out_byte = 8'h1F;
					4'd3: out_byte = 8'h84;
					default: out_byte = 8'h00;
				endcase
			end else begin
				out_byte = B_NOP;
			end
			last = (left == 7'd1);
		end
		out_last = last;
		fire = out_valid && !out_stall;
		pop = fire && last;
	end

	// Walk state for the head entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			left_q <= '0;
			run_q <= '0;
			started_q <= 1'b0;
		end else if (fire) begin
			if (last) begin
				idx_q <= '0;
				started_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 4'd1;
				started_q <= 1'b1;
				left_q <= left - 7'd1;
				if (run != 4'd0 || left >= 7'd9)
					run_q <= (run == 4'd8) ? 4'd0 : run + 4'd1;
				else
					run_q <= 4'd0;
			end
		end
	end
endmodule

### rtl/x86_64_instruction_byte_encoder.sv
// Top level of the x86-64 instruction byte encoder.
// Request channel: in_valid/in_stall with the operand fields. A request is
// taken when in_valid is high and in_stall is low.
// Result channel: out_valid/out_stall with code_byte and last_byte; one beat
// per machine code byte, last_byte marks the final byte of an instruction.
// First byte: the cycle after the request is taken, if the queue was empty.
// Throughput: one byte per cycle while out_stall is low; an instruction has
// 1 to 10 bytes (a padding request has its pad count, up to 64).
// The output byte rate is what sets it; the four-entry queue lets requests
// be taken while earlier instructions are still being sent.
// Unknown kinds and zero padding produce no beats and are dropped.
// Reset empties the queue and the byte walker. While out_stall is high the
// current byte holds, and requests keep being taken until the queue fills.
module x86_64_instruction_byte_encoder (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [4:0] req_type,
	input logic [3:0] first_reg,
	input logic [3:0] second_reg,
	input logic [3:0] cond_code,
	input logic signed [31:0] displacement,
	input logic signed [63:0] immediate,
	input logic [6:0] pad_count,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] code_byte,
	output logic last_byte
);
	import xie_pkg::*;

	desc_t fdesc;
	desc_t qdesc;
	logic emits;
	logic full;
	logic empty;
	logic pop;

	xie_front u_front (
		.req_type(req_type), .first_reg(first_reg), .second_reg(second_reg),
		.cond_code(cond_code), .displacement(displacement), .immediate(immediate),
		.pad_count(pad_count), .desc(fdesc), .emits(emits)
	);

	// Requests with no bytes are dropped instead of queued.
	assign in_stall = full;

	xie_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(in_valid && emits), .wdata(fdesc),
		.full(full), .pop(pop), .empty(empty), .rdata(qdesc)
	);

	xie_back u_back (
		.clk(clk), .arst_n(arst_n), .empty(empty), .desc(qdesc), .pop(pop),
		.out_valid(out_valid), .out_byte(code_byte), .out_last(last_byte),
		.out_stall(out_stall)
	);
endmodule

### rtl/xie_checker.sv
// Port-level checker for the x86-64 instruction byte encoder.
// Depends on the defines header; bound to the top level below.
`include "x86_64_instruction_byte_encoder_defines.svh"
module xie_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [7:0] code_byte,
	input logic last_byte
);
	logic hold;
	logic mid;
	logic [8:0] beat;

	// A held beat, a beat with more bytes behind it, and the full output beat.
	assign hold = out_valid && out_stall;
	assign mid = out_valid && !out_stall && !last_byte;
	assign beat = {last_byte, code_byte};

	`XIE_ASSERT_NEXT(a_out_hold, hold, out_valid && $stable(beat), "held beat changed")
	`XIE_ASSERT_NEXT(a_more_bytes, mid, out_valid, "instruction cut short")
	`XIE_ASSERT_IMP(a_stall_needs_backlog, in_stall, out_valid, "input stalled with no output")
	`XIE_ASSERT_IMP(a_in_known, in_valid, !$isunknown(in_stall), "input stall unknown")
endmodule

bind x86_64_instruction_byte_encoder xie_checker u_xie_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .code_byte(code_byte),
	.last_byte(last_byte)
);
